// File: design/spo_pkg.sv
package spo_pkg;

  // Configuration port
  localparam int CFG_W      = 4;
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_COL_COUNT = 1'b1;

  // Fixed result field widths
  localparam int OUT_VAL_W   = 32;
  localparam int OUT_IDX_W   = 3;
  localparam int OUT_TDATA_W = ((OUT_VAL_W + 2 * OUT_IDX_W + 7) / 8) * 8;

  // Default sizes
  localparam int DEF_MAX_ROWS    = 8;
  localparam int DEF_MAX_COLS    = 8;
  localparam int DEF_VALUE_WIDTH = 32;

  // Matrix dimensions in use, already clamped
  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
  } dims_t;

  // Spiral position handed from the walker to the read side
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
  } pos_t;

  // One result waiting for the output side
  typedef struct packed {
    logic                 last;
    logic [OUT_IDX_W-1:0] col;
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_VAL_W-1:0] value;
  } res_t;

  // Map zero to one and saturate at the maximum
  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] res;
    res = v;
    if (v == '0) res = CFG_W'(1);
    else if (v > maxv) res = maxv;
    return res;
  endfunction

endpackage

// File: design/spo_ram.sv
module spo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// File: design/spo_loader.sv
module spo_loader
  import spo_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_fire,
  input  dims_t dims,
  output logic [(MAX_ROWS * MAX_COLS > 1 ? $clog2(MAX_ROWS * MAX_COLS) : 1)-1:0] wr_addr,
  output logic  done
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int LC_W   = $clog2(DEPTH + 1);
  localparam int RW     = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;

  logic [LC_W-1:0]    load_cnt_r, load_cnt_nxt;
  logic [LC_W-1:0]    eff_cnt, cnt_inc, total;
  logic [2*CFG_W-1:0] total_prod, kprod, rc_prod, eff_ext;
  logic [RW-1:0]      r_sel;
  logic [CW-1:0]      c_sel;

  // Restart the count when the dimensions shrank below it
  always_comb begin
    total_prod = dims.rows * dims.cols;
    total      = LC_W'(total_prod);
    eff_cnt    = (load_cnt_r >= total) ? '0 : load_cnt_r;
    eff_ext    = (2*CFG_W)'(eff_cnt);
  end

  // Split the count into row and column: row is the largest k with k*cols <= count
  always_comb begin
    kprod = '0;
    r_sel = '0;
    for (int k = 1; k < MAX_ROWS; k++) begin
      kprod = CFG_W'(k) * dims.cols;
      if (kprod <= eff_ext) r_sel = RW'(k);
    end
    rc_prod = r_sel * dims.cols;
    c_sel   = CW'(eff_ext - rc_prod);
    wr_addr = ADDR_W'(r_sel * MAX_COLS + c_sel);
  end

  // Advance the count and flag the element that completes the matrix
  always_comb begin
    cnt_inc      = eff_cnt + LC_W'(1);
    done         = in_fire && (cnt_inc == total);
    load_cnt_nxt = load_cnt_r;
    if (in_fire) load_cnt_nxt = done ? '0 : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
    end
  end

endmodule

// File: design/spo_walker.sv
module spo_walker
  import spo_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  dims_t dims,
  input  logic  step,
  output pos_t  pos
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int LC_W  = $clog2(DEPTH + 1);
  localparam int RW    = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_t;

  dir_t               dir_r;
  logic               busy_r;
  logic [RW-1:0]      row_r, top_r, bot_r;
  logic [CW-1:0]      col_r, left_r, right_r;
  logic [LC_W-1:0]    remain_r;
  logic [2*CFG_W-1:0] total_prod;
  logic               last;

  assign total_prod = dims.rows * dims.cols;
  assign last       = (remain_r == LC_W'(1));

  assign pos.valid = busy_r;
  assign pos.last  = last;
  assign pos.row   = OUT_IDX_W'(row_r);
  assign pos.col   = OUT_IDX_W'(col_r);

  // Walk the ring: turn at each bound and pull the bound of the side just walked inward
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dir_r  <= DIR_RIGHT;
    end else if (start) begin
      busy_r   <= 1'b1;
      dir_r    <= DIR_RIGHT;
      row_r    <= '0;
      col_r    <= '0;
      top_r    <= '0;
      left_r   <= '0;
      bot_r    <= RW'(dims.rows - CFG_W'(1));
      right_r  <= CW'(dims.cols - CFG_W'(1));
      remain_r <= LC_W'(total_prod);
    end else if (step && busy_r) begin
      remain_r <= remain_r - LC_W'(1);
      if (last) busy_r <= 1'b0;
      unique case (dir_r)
        DIR_RIGHT: begin
          if (col_r == right_r) begin
            dir_r <= DIR_DOWN;
            top_r <= top_r + RW'(1);
            row_r <= row_r + RW'(1);
          end else begin
            col_r <= col_r + CW'(1);
          end
        end
        DIR_DOWN: begin
          if (row_r == bot_r) begin
            dir_r   <= DIR_LEFT;
            right_r <= right_r - CW'(1);
            col_r   <= col_r - CW'(1);
          end else begin
            row_r <= row_r + RW'(1);
          end
        end
        DIR_LEFT: begin
          if (col_r == left_r) begin
            dir_r <= DIR_UP;
            bot_r <= bot_r - RW'(1);
            row_r <= row_r - RW'(1);
          end else begin
            col_r <= col_r - CW'(1);
          end
        end
        DIR_UP: begin
          if (row_r == top_r) begin
            dir_r  <= DIR_RIGHT;
            left_r <= left_r + CW'(1);
            col_r  <= col_r + CW'(1);
          end else begin
            row_r <= row_r - RW'(1);
          end
        end
        default: dir_r <= DIR_RIGHT;
      endcase
    end
  end

endmodule

// File: design/spiral_order_reorder.sv
// Channel   Direction  Handshake         Payload
// in_       input      tvalid / tready   tdata: element_value
// out_      output     tvalid / tready   tdata: out_value, out_row, out_col; tlast: end_of_run
// cfg_      input      wr_en             addr: register index, wdata: register value
//
// Loading takes one element per cycle while in_tready is high. The element that completes the
// matrix starts the spiral; out_tvalid rises after the walker start register, the memory read
// and the output register, and results follow one per cycle while out_tready is high.
// in_tready stays low until the last spiral read is issued. Reset (rst_n, synchronous)
// clears the load count, the walker and the output queue; the store itself is not cleared.
// A stalled out_tready pauses the reads.
module spiral_order_reorder
  import spo_pkg::*;
#(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] in_tdata,  // element_value
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [OUT_TDATA_W-1:0]                out_tdata, // out_value, out_row, out_col
  output logic                                  out_tlast,
  input  logic                                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]                 cfg_addr,
  input  logic [CFG_W-1:0]                      cfg_wdata
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;

  logic [CFG_W-1:0]       row_count_r, col_count_r;
  dims_t                  dims;
  logic                   in_fire, load_done;
  logic [ADDR_W-1:0]      wr_addr, rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;
  pos_t                   pos, pend_r;
  logic                   issue, take;
  logic [1:0]             used;
  res_t                   arr, out_r, skid_r;
  logic                   out_valid_r, skid_valid_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CFG_W'(8);
      col_count_r <= CFG_W'(8);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_ROW_COUNT: row_count_r <= cfg_wdata;
        REG_COL_COUNT: col_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign dims.rows = clamp_dim(row_count_r, CFG_W'(MAX_ROWS));
  assign dims.cols = clamp_dim(col_count_r, CFG_W'(MAX_COLS));

  assign in_tready = !pos.valid;
  assign in_fire   = in_tvalid && in_tready;

  spo_loader #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_loader (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_fire(in_fire),
    .dims   (dims),
    .wr_addr(wr_addr),
    .done   (load_done)
  );

  spo_walker #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_walker (
    .clk  (clk),
    .rst_n(rst_n),
    .start(load_done),
    .dims (dims),
    .step (issue),
    .pos  (pos)
  );

  // Issue a read only when the output queue has room for its data
  always_comb begin
    take  = out_valid_r && out_tready;
    used  = 2'(out_valid_r) + 2'(skid_valid_r) + 2'(pend_r.valid) - 2'(take);
    issue = pos.valid && (used < 2'd2);
  end

  assign rd_addr = ADDR_W'(int'(pos.row) * MAX_COLS + int'(pos.col));

  // The first read waits for the walker start register after the last write, so no forwarding is needed
  spo_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (in_fire),
    .wr_addr(wr_addr),
    .wr_data(in_tdata[VALUE_WIDTH-1:0]),
    .rd_en  (issue),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Hold the position of the read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r.valid <= 1'b0;
    end else begin
      pend_r.valid <= issue;
    end
    if (issue) begin
      pend_r.last <= pos.last;
      pend_r.row  <= pos.row;
      pend_r.col  <= pos.col;
    end
  end

  assign arr.last  = pend_r.last;
  assign arr.row   = pend_r.row;
  assign arr.col   = pend_r.col;
  assign arr.value = OUT_VAL_W'(rd_data);

  // Output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= pend_r.valid;
      end else begin
        out_valid_r <= pend_r.valid;
      end
    end else if (pend_r.valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
        if (pend_r.valid) skid_r <= arr;
      end else if (pend_r.valid) begin
        out_r <= arr;
      end
    end else if (pend_r.valid) begin
      skid_r <= arr;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_r.last;
  assign out_tdata  = OUT_TDATA_W'({out_r.col, out_r.row, out_r.value});

endmodule
